// ===== sv/hvd_pkg.sv =====
// shared constants, types and helper functions for the haversine distance pipeline
package hvd_pkg;

  localparam int ANGLE_FRAC_BITS = 20;
  localparam int DIST_FRAC_BITS  = 8;
  localparam int CORDIC_STAGES   = 24;

  localparam int LAT_W     = 28;
  localparam int LON_W     = 29;
  localparam int DIST_W    = 23;
  localparam int ANG_W     = 30;
  localparam int XY_W      = 35;
  localparam int Z_W       = 33;
  localparam int CFG_W     = 29;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LON = 2'd1;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam int          EARTH_R = 6371;
  localparam int          ARC_SCALE = 2 * EARTH_R;
  localparam int          PROD_W  = 46;

  // divide by 45 as a multiply by ceil(2^43 / 45), exact for numerators below 2^37
  localparam int               DIV_BITS    = 40;
  localparam int               RECIP_W     = 38;
  localparam int               RECIP_SHIFT = 43;
  localparam logic [RECIP_W-1:0] RECIP_45  = 38'd195468733827;

  localparam int SQRT_STEPS = 32;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  ang_t;

  localparam xy_t GAIN_INV = 35'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam logic [63:0] CAP_FULL =
    ((64'(PI_Q30) * 64'(EARTH_R)) << DIST_FRAC_BITS) >> 30;
  localparam logic [DIST_W-1:0] OUT_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_CAP =
    (CAP_FULL > 64'(OUT_MAX)) ? OUT_MAX : CAP_FULL[DIST_W-1:0];

  // atan(2^-i) in q30 radians
  function automatic ang_t atan_q30(input int i);
    case (i)
      0:  atan_q30 = 33'sd843314857;
      1:  atan_q30 = 33'sd497837829;
      2:  atan_q30 = 33'sd263043837;
      3:  atan_q30 = 33'sd133525159;
      4:  atan_q30 = 33'sd67021687;
      5:  atan_q30 = 33'sd33543516;
      6:  atan_q30 = 33'sd16775851;
      7:  atan_q30 = 33'sd8388437;
      8:  atan_q30 = 33'sd4194283;
      9:  atan_q30 = 33'sd2097149;
      10: atan_q30 = 33'sd1048576;
      11: atan_q30 = 33'sd524288;
      12: atan_q30 = 33'sd262144;
      13: atan_q30 = 33'sd131072;
      14: atan_q30 = 33'sd65536;
      15: atan_q30 = 33'sd32768;
      16: atan_q30 = 33'sd16384;
      17: atan_q30 = 33'sd8192;
      18: atan_q30 = 33'sd4096;
      19: atan_q30 = 33'sd2048;
      20: atan_q30 = 33'sd1024;
      21: atan_q30 = 33'sd512;
      22: atan_q30 = 33'sd256;
      23: atan_q30 = 33'sd128;
      24: atan_q30 = 33'sd64;
      25: atan_q30 = 33'sd32;
      26: atan_q30 = 33'sd16;
      27: atan_q30 = 33'sd8;
      28: atan_q30 = 33'sd4;
      29: atan_q30 = 33'sd2;
      30: atan_q30 = 33'sd1;
      31: atan_q30 = 33'sd1;
      default: atan_q30 = '0;
    endcase
  endfunction

  // q30 product, rounded, floor shift
  function automatic xy_t mul_q30(input xy_t a, input xy_t b);
    logic signed [2*XY_W-1:0] p;
    p = a * b;
    p = p + ((2*XY_W)'(1) <<< 29);
    mul_q30 = XY_W'(p >>> 30);
  endfunction

endpackage

// ===== sv/hvd_angle_prep.sv =====
// angle wrap, quadrant split and conversion to q30 radians
module hvd_angle_prep #(
  parameter int FB = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [hvd_pkg::ANG_W-1:0]  in_ang,
  output logic                              out_vld,
  output hvd_pkg::ang_t                     out_z,
  output logic [1:0]                        out_q
);
  import hvd_pkg::*;

  localparam int REM_W = FB + 7;
  localparam int HALF_W = DIV_BITS / 2;
  localparam int MH_W = RECIP_W / 2;
  localparam int PP_W = HALF_W + MH_W;
  localparam int SUM_W = DIV_BITS + RECIP_W;
  localparam logic signed [31:0] FULL = 32'(longint'(360) << FB);
  localparam logic signed [31:0] QTR1 = 32'(longint'(90) << FB);
  localparam logic signed [31:0] QTR2 = 32'(longint'(180) << FB);
  localparam logic signed [31:0] QTR3 = 32'(longint'(270) << FB);
  localparam logic [63:0] HALF_D = 64'(longint'(90) << FB);

  logic signed [31:0] v_w, r_w, sub_w;
  logic [1:0]         q_nxt;
  logic [REM_W-1:0]   rem_nxt;
  logic [REM_W-1:0]   rem_r;
  logic [1:0]         q1_r, q2_r, q3_r, q4_r, q5_r;
  logic               vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;
  logic [63:0]        n_w;

  logic [DIV_BITS-1:0] x_r;
  logic [PP_W-1:0]     hh_r, hl_r, lh_r, ll_r;
  logic [SUM_W-1:0]    cat_r, sum_w;
  logic [PP_W+1:0]     mid_r;
  logic [Z_W-2:0]      quo_r;

  always_comb begin
    v_w = 32'(in_ang);
    r_w = (v_w < 0) ? v_w + FULL : v_w;
    if (r_w >= QTR3) begin
      q_nxt = 2'd3;
      sub_w = QTR3;
    end else if (r_w >= QTR2) begin
      q_nxt = 2'd2;
      sub_w = QTR2;
    end else if (r_w >= QTR1) begin
      q_nxt = 2'd1;
      sub_w = QTR1;
    end else begin
      q_nxt = 2'd0;
      sub_w = '0;
    end
    rem_nxt = REM_W'(r_w - sub_w);
  end

  assign n_w = 64'(rem_r) * 64'(PI_Q30) + HALF_D;

  // reciprocal product of the numerator, summed from four partial products
  assign sum_w = cat_r + (SUM_W'(mid_r) << MH_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q1_r  <= q_nxt;
      x_r   <= DIV_BITS'(n_w >> (FB + 2));
      q2_r  <= q1_r;
      hh_r  <= PP_W'(x_r[DIV_BITS-1:HALF_W]) * PP_W'(RECIP_45[RECIP_W-1:MH_W]);
      hl_r  <= PP_W'(x_r[DIV_BITS-1:HALF_W]) * PP_W'(RECIP_45[MH_W-1:0]);
      lh_r  <= PP_W'(x_r[HALF_W-1:0]) * PP_W'(RECIP_45[RECIP_W-1:MH_W]);
      ll_r  <= PP_W'(x_r[HALF_W-1:0]) * PP_W'(RECIP_45[MH_W-1:0]);
      q3_r  <= q2_r;
      cat_r <= {hh_r, ll_r};
      mid_r <= {1'b0, hl_r, 1'b0} + (PP_W+2)'(lh_r);
      q4_r  <= q3_r;
      quo_r <= sum_w[RECIP_SHIFT +: Z_W-1];
      q5_r  <= q4_r;
    end
  end

  assign out_vld = vld5_r;
  assign out_z   = {1'b0, quo_r};
  assign out_q   = q5_r;

endmodule

// ===== sv/hvd_cordic_rot.sv =====
// rotation cordic giving cosine and sine, one iteration per stage
module hvd_cordic_rot (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  hvd_pkg::ang_t in_z,
  input  logic [1:0]    in_q,
  output logic          out_vld,
  output hvd_pkg::xy_t  out_co,
  output hvd_pkg::xy_t  out_si
);
  import hvd_pkg::*;

  localparam int N = CORDIC_STAGES;

  xy_t        x_r   [0:N];
  xy_t        y_r   [0:N];
  ang_t       z_r   [0:N];
  logic [1:0] q_r   [0:N];
  logic       vld_r [0:N];

  xy_t  x_nxt [0:N-1];
  xy_t  y_nxt [0:N-1];
  ang_t z_nxt [0:N-1];

  xy_t  co_nxt, si_nxt;
  xy_t  co_r, si_r;
  logic ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_INV;
      y_r[0] <= '0;
      z_r[0] <= in_z;
      q_r[0] <= in_q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_comb begin
      xy_t xs;
      xy_t ys;
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      if (z_r[i] >= 0) begin
        x_nxt[i] = x_r[i] - ys;
        y_nxt[i] = y_r[i] + xs;
        z_nxt[i] = z_r[i] - atan_q30(i);
      end else begin
        x_nxt[i] = x_r[i] + ys;
        y_nxt[i] = y_r[i] - xs;
        z_nxt[i] = z_r[i] + atan_q30(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt[i];
        y_r[i+1] <= y_nxt[i];
        z_r[i+1] <= z_nxt[i];
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // quadrant fold
  always_comb begin
    case (q_r[N])
      2'd0: begin
        co_nxt = x_r[N];
        si_nxt = y_r[N];
      end
      2'd1: begin
        co_nxt = -y_r[N];
        si_nxt = x_r[N];
      end
      2'd2: begin
        co_nxt = -x_r[N];
        si_nxt = -y_r[N];
      end
      default: begin
        co_nxt = y_r[N];
        si_nxt = -x_r[N];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      co_r <= co_nxt;
      si_r <= si_nxt;
    end
  end

  assign out_vld = ov_r;
  assign out_co  = co_r;
  assign out_si  = si_r;

endmodule

// ===== sv/hvd_isqrt.sv =====
// pipelined integer floor square root, one result bit per stage
module hvd_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] in_n,
  output logic        out_vld,
  output logic [31:0] out_root
);
  import hvd_pkg::*;

  localparam int S = SQRT_STEPS;

  logic [63:0] rm_r  [0:S];
  logic [63:0] rs_r  [0:S];
  logic        vld_r [0:S];
  logic [63:0] rm_nxt [0:S-1];
  logic [63:0] rs_nxt [0:S-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm_r[0] <= in_n;
      rs_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (2 * (S - 1 - k));

    always_comb begin
      logic [63:0] t;
      t = rs_r[k] + BIT;
      if (rm_r[k] >= t) begin
        rm_nxt[k] = rm_r[k] - t;
        rs_nxt[k] = (rs_r[k] >> 1) + BIT;
      end else begin
        rm_nxt[k] = rm_r[k];
        rs_nxt[k] = rs_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[k+1] <= rm_nxt[k];
        rs_r[k+1] <= rs_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[S];
  assign out_root = rs_r[S][31:0];

endmodule

// ===== sv/hvd_arc.sv =====
// vectoring cordic for the arc angle and scaling to a saturated distance
module hvd_arc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [31:0]                   in_sa,
  input  logic [31:0]                   in_sb,
  output logic                          out_vld,
  output logic [hvd_pkg::DIST_W-1:0]    out_dist
);
  import hvd_pkg::*;

  localparam int N = CORDIC_STAGES;

  xy_t  x_r   [0:N];
  xy_t  y_r   [0:N];
  ang_t z_r   [0:N];
  logic vld_r [0:N];

  xy_t  x_nxt [0:N-1];
  xy_t  y_nxt [0:N-1];
  ang_t z_nxt [0:N-1];

  logic [31:0]        zc_w;
  logic [PROD_W-1:0]  prod_nxt, prod_r;
  logic               pv_r;
  logic [63:0]        d_w;
  logic [DIST_W-1:0]  dist_nxt, dist_r;
  logic               dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= XY_W'(in_sb);
      y_r[0] <= XY_W'(in_sa);
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_comb begin
      xy_t xs;
      xy_t ys;
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      if (y_r[i] > 0) begin
        x_nxt[i] = x_r[i] + ys;
        y_nxt[i] = y_r[i] - xs;
        z_nxt[i] = z_r[i] + atan_q30(i);
      end else begin
        x_nxt[i] = x_r[i] - ys;
        y_nxt[i] = y_r[i] + xs;
        z_nxt[i] = z_r[i] - atan_q30(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt[i];
        y_r[i+1] <= y_nxt[i];
        z_r[i+1] <= z_nxt[i];
      end
    end
  end

  // negative residue clamps to zero
  assign zc_w     = (z_r[N] < 0) ? '0 : z_r[N][31:0];
  assign prod_nxt = PROD_W'(zc_w) * PROD_W'(ARC_SCALE);

  always_comb begin
    d_w = ((64'(prod_r) << DIST_FRAC_BITS) + (64'd1 << 29)) >> 30;
    dist_nxt = (d_w > 64'(DIST_CAP)) ? DIST_CAP : d_w[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      dv_r <= 1'b0;
    end else if (en) begin
      pv_r <= vld_r[N];
      dv_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign out_vld  = dv_r;
  assign out_dist = dist_r;

endmodule

// ===== sv/haversine_distance_top.sv =====
// haversine great-circle distance pipeline, top level
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_point_latitude, in_point_longitude
//  out     | output    | out_valid / out_ready | out_distance_km
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// one point accepted per cycle while in_ready is high; from transfer to result a point
// passes the input register, angle prep, rotation cordic, three product stages,
// square root stages, vectoring cordic and scaling
// synchronous active-low reset clears the valid bits and the output buffer
// a two-entry output buffer holds results; the whole pipe stalls only when it is full
module haversine_distance_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hvd_pkg::LAT_W-1:0]    in_point_latitude,
  input  logic signed [hvd_pkg::LON_W-1:0]    in_point_longitude,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hvd_pkg::DIST_W-1:0]          out_distance_km,
  input  logic                                cfg_we,
  input  logic [hvd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hvd_pkg::CFG_W-1:0]           cfg_data
);
  import hvd_pkg::*;

  logic signed [LAT_W-1:0] qlat_r;
  logic signed [LON_W-1:0] qlon_r;

  logic en;
  logic [1:0] cnt_r, cnt_nxt;
  logic [DIST_W-1:0] d0_r, d1_r, d0_nxt, d1_nxt;

  logic signed [ANG_W-1:0] lat1_r, lat2_r, dlat_r, dlon_r;
  logic                    s0_vld_r;

  ang_t       z_lat1, z_lat2, z_dlat, z_dlon;
  logic [1:0] q_lat1, q_lat2, q_dlat, q_dlon;
  logic       p_vld;

  xy_t  c1, c2, sh, sw;
  logic r_vld;

  xy_t  p_sh_r, p_sw_r, p_cc_r, p_sh2_r, p_t_r;
  logic m1_vld_r, m2_vld_r, m3_vld_r;
  logic signed [XY_W:0] a_w;
  logic [30:0] a_r;

  logic        sa_vld;
  logic [31:0] sa, sb;
  logic        arc_vld;
  logic [DIST_W-1:0] arc_dist;
  logic push, pop;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlat_r <= '0;
      qlon_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUERY_LAT: qlat_r <= cfg_data[LAT_W-1:0];
        CFG_QUERY_LON: qlon_r <= cfg_data[LON_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= ANG_W'(qlat_r);
      lat2_r <= ANG_W'(in_point_latitude);
      dlat_r <= ANG_W'(in_point_latitude) - ANG_W'(qlat_r);
      dlon_r <= ANG_W'(in_point_longitude) - ANG_W'(qlon_r);
    end
  end

  hvd_angle_prep #(.FB(ANGLE_FRAC_BITS)) u_prep_lat1 (
    .clk, .rst_n, .en, .in_vld(s0_vld_r), .in_ang(lat1_r),
    .out_vld(p_vld), .out_z(z_lat1), .out_q(q_lat1)
  );
  hvd_angle_prep #(.FB(ANGLE_FRAC_BITS)) u_prep_lat2 (
    .clk, .rst_n, .en, .in_vld(s0_vld_r), .in_ang(lat2_r),
    .out_vld(), .out_z(z_lat2), .out_q(q_lat2)
  );
  hvd_angle_prep #(.FB(ANGLE_FRAC_BITS + 1)) u_prep_dlat (
    .clk, .rst_n, .en, .in_vld(s0_vld_r), .in_ang(dlat_r),
    .out_vld(), .out_z(z_dlat), .out_q(q_dlat)
  );
  hvd_angle_prep #(.FB(ANGLE_FRAC_BITS + 1)) u_prep_dlon (
    .clk, .rst_n, .en, .in_vld(s0_vld_r), .in_ang(dlon_r),
    .out_vld(), .out_z(z_dlon), .out_q(q_dlon)
  );

  hvd_cordic_rot u_rot_lat1 (
    .clk, .rst_n, .en, .in_vld(p_vld), .in_z(z_lat1), .in_q(q_lat1),
    .out_vld(r_vld), .out_co(c1), .out_si()
  );
  hvd_cordic_rot u_rot_lat2 (
    .clk, .rst_n, .en, .in_vld(p_vld), .in_z(z_lat2), .in_q(q_lat2),
    .out_vld(), .out_co(c2), .out_si()
  );
  hvd_cordic_rot u_rot_dlat (
    .clk, .rst_n, .en, .in_vld(p_vld), .in_z(z_dlat), .in_q(q_dlat),
    .out_vld(), .out_co(), .out_si(sh)
  );
  hvd_cordic_rot u_rot_dlon (
    .clk, .rst_n, .en, .in_vld(p_vld), .in_z(z_dlon), .in_q(q_dlon),
    .out_vld(), .out_co(), .out_si(sw)
  );

  // haversine term
  assign a_w = (XY_W+1)'(p_sh2_r) + (XY_W+1)'(p_t_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= r_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_sh_r  <= mul_q30(sh, sh);
      p_sw_r  <= mul_q30(sw, sw);
      p_cc_r  <= mul_q30(c1, c2);
      p_sh2_r <= p_sh_r;
      p_t_r   <= mul_q30(p_cc_r, p_sw_r);
      if (a_w < 0) begin
        a_r <= '0;
      end else if (a_w > (XY_W+1)'(ONE_Q30)) begin
        a_r <= ONE_Q30;
      end else begin
        a_r <= a_w[30:0];
      end
    end
  end

  hvd_isqrt u_sqrt_a (
    .clk, .rst_n, .en, .in_vld(m3_vld_r), .in_n(64'(a_r) << 30),
    .out_vld(sa_vld), .out_root(sa)
  );
  hvd_isqrt u_sqrt_b (
    .clk, .rst_n, .en, .in_vld(m3_vld_r), .in_n(64'(ONE_Q30 - a_r) << 30),
    .out_vld(), .out_root(sb)
  );

  hvd_arc u_arc (
    .clk, .rst_n, .en, .in_vld(sa_vld), .in_sa(sa), .in_sb(sb),
    .out_vld(arc_vld), .out_dist(arc_dist)
  );

  // output buffer
  assign push = arc_vld & en;
  assign pop  = out_valid & out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          d0_nxt = arc_dist;
        end else begin
          d1_nxt = arc_dist;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        d0_nxt  = d1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        d0_nxt = arc_dist;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_distance_km = d0_r;

endmodule

// ===== sv/hvd_checker.sv =====
// port-level checks for the haversine distance top level, with bind
module hvd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [hvd_pkg::DIST_W-1:0]   out_distance_km
);
  import hvd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_km))
    else $error("stalled result changed");

  a_out_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_km <= DIST_CAP)
    else $error("distance above half circumference");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("buffer not empty after reset");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind haversine_distance_top hvd_checker u_hvd_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for the haversine distance pipeline
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hvd_pkg::*;

  localparam longint unsigned PI_Q62_C = 64'hC90FDAA22168C235;
  localparam longint unsigned PI_Q30_C = 64'd3373259426;
  localparam longint GAIN_C = 652032874;
  localparam longint ONE_C = longint'(1) << 30;
  localparam int STALL_LIMIT = 20000;

  class distance_board;
    logic [DIST_W-1:0] pending[$];
    int errors = 0;
    int checked = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note(logic [DIST_W-1:0] d);
      pending.push_back(d);
    endfunction

    task check(logic [DIST_W-1:0] d);
      logic [DIST_W-1:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected distance %0d", d));
      end else begin
        want = pending.pop_front();
        checked++;
        if (want !== d) report($sformatf("distance got %0d want %0d", d, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [LAT_W-1:0] in_point_latitude = '0;
  logic signed [LON_W-1:0] in_point_longitude = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] out_distance_km;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [LAT_W-1:0] q_lat = '0;
  logic [LON_W-1:0] q_lon = '0;
  bit quiet = 1'b0;
  int stall_count = 0;
  int sent = 0;
  distance_board board = new();
  longint arctan_tab[CORDIC_STAGES];

  haversine_distance_top i_dut (.*);

  always #1 clk = ~clk;

  function automatic longint arctan_step(int i);
    longint unsigned sum, term, k, d;
    if (i == 0) return longint'(((PI_Q62_C >> 2) + (64'd1 << 31)) >> 32);
    term = 64'd1 << (62 - i);
    sum = 0;
    k = 0;
    while (term != 0) begin
      d = term / (2 * k + 1);
      if (k[0] == 1'b0) sum += d;
      else sum -= d;
      term >>= 2 * i;
      k++;
    end
    return longint'((sum + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic void rotate(longint v, int fb, output longint co, output longint si);
    longint full, quarter, r, q, rem, x, y, z, xs, ys;
    longint unsigned half_turn;
    full = longint'(360) << fb;
    quarter = longint'(90) << fb;
    half_turn = longint'(180) << fb;
    r = v % full;
    if (r < 0) r += full;
    q = r / quarter;
    rem = r - q * quarter;
    z = longint'((longint'(unsigned'(rem)) * PI_Q30_C + (half_turn >> 1)) / half_turn);
    x = GAIN_C;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_tab[i];
      end else begin
        x += ys; y -= xs; z += arctan_tab[i];
      end
    end
    case (q & 3)
      0: begin co = x; si = y; end
      1: begin co = -y; si = x; end
      2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DIST_W-1:0] great_circle(logic [LAT_W-1:0] qa,
      logic [LON_W-1:0] qo, logic [LAT_W-1:0] pa, logic [LON_W-1:0] po);
    longint lat1, lon1, lat2, lon2, c1, s1, c2, s2, ch, sh, cw, sw, a, x, y, z, xs, ys;
    longint unsigned sa, sb, d, cap;
    lat1 = longint'(signed'(qa));
    lon1 = longint'(signed'(qo));
    lat2 = longint'(signed'(pa));
    lon2 = longint'(signed'(po));
    rotate(lat1, ANGLE_FRAC_BITS, c1, s1);
    rotate(lat2, ANGLE_FRAC_BITS, c2, s2);
    rotate(lat2 - lat1, ANGLE_FRAC_BITS + 1, ch, sh);
    rotate(lon2 - lon1, ANGLE_FRAC_BITS + 1, cw, sw);
    a = qmul(sh, sh) + qmul(qmul(c1, c2), qmul(sw, sw));
    if (a < 0) a = 0;
    if (a > ONE_C) a = ONE_C;
    sa = int_sqrt(longint'(unsigned'(a)) << 30);
    sb = int_sqrt(longint'(unsigned'(ONE_C - a)) << 30);
    x = longint'(sb);
    y = longint'(sa);
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += arctan_tab[i];
      end else begin
        x -= ys; y += xs; z -= arctan_tab[i];
      end
    end
    if (z < 0) z = 0;
    d = (longint'(unsigned'(z)) * (2 * EARTH_R)) << DIST_FRAC_BITS;
    d = (d + (64'd1 << 29)) >> 30;
    cap = ((PI_Q30_C * EARTH_R) << DIST_FRAC_BITS) >> 30;
    if (d > cap) d = cap;
    if (d > 64'h7FFFFF) d = 64'h7FFFFF;
    return d[DIST_W-1:0];
  endfunction

  // transfer monitor and config shadow
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_QUERY_LAT) q_lat <= cfg_data[LAT_W-1:0];
        else if (cfg_index == CFG_QUERY_LON) q_lon <= cfg_data[LON_W-1:0];
      end
      if (in_valid && in_ready)
        board.note(great_circle(q_lat, q_lon, in_point_latitude, in_point_longitude));
      if (out_valid && out_ready) board.check(out_distance_km);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("watchdog expired");
        $display("FAIL haversine_distance_top");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
  end

  task automatic send(logic [LAT_W-1:0] lat, logic [LON_W-1:0] lon);
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_latitude <= lat;
    in_point_longitude <= lon;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_points(int n);
    logic [LAT_W-1:0] la;
    logic [LON_W-1:0] lo;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        la = LAT_W'($urandom_range(188743680) - 94371840);
        lo = LON_W'($urandom_range(377487360) - 188743680);
      end else begin
        la = LAT_W'($urandom());
        lo = LON_W'($urandom());
      end
      send(la, lo);
    end
  endtask

  initial begin
    for (int i = 0; i < CORDIC_STAGES; i++) arctan_tab[i] = arctan_step(i);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed points against the reset query
    send(0, 0);
    send(28'sd94371840, 0);
    send(-28'sd94371840, 0);
    send(0, 29'sd188743680);
    send(0, -29'sd188743680);
    send(28'sd94371840, 29'sd188743680);
    send(-28'sd94371840, -29'sd188743680);
    send(28'h7FFFFFF, 29'h0FFFFFFF);
    send(28'h8000000, 29'h10000000);
    send(28'hFFFFFFF, 29'h1FFFFFFF);
    send(28'sd1, 29'sd1);
    send(28'sd47185920, 29'sd94371840);
    send(28'sd100000000, 29'sd250000000);
    drain();

    // antipodes and coincident points with a nonzero query
    write_cfg(CFG_QUERY_LAT, 29'sd47185920);
    write_cfg(CFG_QUERY_LON, 29'sd94371840);
    send(28'sd47185920, 29'sd94371840);
    send(-28'sd47185920, -29'sd94371840);
    send(28'sd47185921, 29'sd94371840);
    send(-28'sd47185920, 29'sd94371840 - 29'sd188743680);
    drain();

    // extremes of the query, then unused register indexes
    write_cfg(CFG_QUERY_LAT, 29'sd94371840);
    write_cfg(CFG_QUERY_LON, 29'sd188743680);
    random_points(150);
    drain();
    write_cfg(CFG_QUERY_LAT, -29'sd94371840);
    write_cfg(CFG_QUERY_LON, -29'sd188743680);
    write_cfg(2'd2, 29'h1FFFFFFF);
    write_cfg(2'd3, 29'h0AAAAAAA);
    random_points(150);
    drain();
    write_cfg(CFG_QUERY_LAT, 29'h1FFFFFFF);
    write_cfg(CFG_QUERY_LON, 29'h10000000);
    random_points(150);
    drain();

    quiet = 1'b1;
    random_points(250);
    quiet = 1'b0;
    drain();

    for (int p = 0; p < 4; p++) begin
      write_cfg(CFG_QUERY_LAT, CFG_W'($urandom_range(188743680) - 94371840));
      write_cfg(CFG_QUERY_LON, CFG_W'($urandom_range(377487360) - 188743680));
      random_points(130);
      drain();
    end

    $display("sent %0d points over nine query settings, %0d distances checked",
             sent, board.checked);
    $display("covered extremes, wrapped angles, antipodes and back-pressure");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS haversine_distance_top");
    end else begin
      $display("FAIL haversine_distance_top");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/hvd_pkg.sv
sv/hvd_angle_prep.sv
sv/hvd_cordic_rot.sv
sv/hvd_isqrt.sv
sv/hvd_arc.sv
sv/haversine_distance_top.sv
sv/hvd_checker.sv
sim/testbench.sv
